// ----- sv/cbfns_pkg.sv -----
// ----------------------------------------------------------------------------
// cbfns_pkg
// Shared types and constants of the circular find-next-set bitmap unit.
// ----------------------------------------------------------------------------
package cbfns_pkg;

   // Fixed field widths
   localparam int unsigned OPCODE_W = 2;
   localparam int unsigned POS_W    = 12;
   localparam int unsigned CNT_W    = 13;

   // Parameter defaults
   localparam int unsigned DEF_MAX_BITS  = 4096;
   localparam int unsigned DEF_WORD_BITS = 64;

   // Positions in use after reset
   localparam int unsigned RESET_COUNT = 4096;

   // Search word is split in byte groups for the two-level priority encode
   localparam int unsigned GRP_BITS = 8;
   localparam int unsigned GLW      = $clog2(GRP_BITS);

   typedef enum logic [OPCODE_W-1:0] {
      OP_FIND   = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_TEST   = 2'd2,
      OP_REFILL = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_DIV,
      ST_SPLIT,
      ST_SCAN,
      ST_READ,
      ST_MODIFY,
      ST_REFILL,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic req_open;
      logic sweep_step;
      logic divide;
      logic split;
      logic scan_run;
      logic scan_issue;
      logic rd_issue;
      logic modify;
      logic load_rsp;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic   req_fire;
      logic   csr_fire;
      op_type op;
      logic   in_range;
      logic   sweep_last;
      logic   issue_done;
      logic   pipe_empty;
      logic   hit;
      logic   rsp_free;
   } sts_type;

endpackage

// ----- sv/cbfns_if.sv -----
// ----------------------------------------------------------------------------
// cbfns interfaces
// Request, response and register-write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cbfns_req_if import cbfns_pkg::*;;
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [POS_W-1:0]    position;

   modport source (output valid, opcode, position, input ready);
   modport sink   (input valid, opcode, position, output ready);
endinterface

interface cbfns_rsp_if import cbfns_pkg::*;;
   logic             valid;
   logic             ready;
   logic             found;
   logic [POS_W-1:0] live_index;
   logic             bit_value;

   modport source (output valid, found, live_index, bit_value, input ready);
   modport sink   (input valid, found, live_index, bit_value, output ready);
endinterface

interface cbfns_csr_if import cbfns_pkg::*;;
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] bit_count;

   modport source (output valid, bit_count, input ready);
   modport sink   (input valid, bit_count, output ready);
endinterface

// ----- sv/circular_bitmap_find_next_set_unit.sv -----
// ----------------------------------------------------------------------------
// circular_bitmap_find_next_set_unit
// Live-position bitmap with clear, test, refill and circular find-next-live.
// ----------------------------------------------------------------------------
// Usage
//   req_if : one request per handshake: opcode (find, clear, test, refill)
//            and a position. Requests are served one at a time.
//   rsp_if : one response per request: found, live_index, bit_value. Fields
//            with no meaning for the opcode read 0.
//   csr_if : writes bit_count (clamped to MAX_BITS) and refills the bitmap.
// Operation, W = used words = ceil(count/WORD_BITS):
//   find reads one word a cycle, W + 1 reads with the
//   wrapped start word, through a three-stage read/encode pipeline;
//   clear and test do a read-modify-write on the word memory;
//   refill rewrites all WORD_COUNT words, one word written a cycle.
// The next request is taken once the last response is loaded into the output register.
// Reset and every bit_count write start a fill sweep over all WORD_COUNT words
// (64 at default size); no request is taken until it ends.
// The response sits in an output register; a stalled receiver holds it
// there, the next request is still taken and worked on, and only its
// response waits for the register to free.
// ----------------------------------------------------------------------------
module circular_bitmap_find_next_set_unit import cbfns_pkg::*; #(
   parameter int unsigned MAX_BITS  = DEF_MAX_BITS,
   parameter int unsigned WORD_BITS = DEF_WORD_BITS
) (
   input  logic        clock,
   input  logic        reset,
   cbfns_req_if.sink   req_if,
   cbfns_rsp_if.source rsp_if,
   cbfns_csr_if.sink   csr_if
);

   // command and status between sequencer and datapath
   cmd_type cmd;
   sts_type sts;

   // sequencer: sweep, decode, scan, read-modify-write, response hand-off
   cbfns_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   // datapath: word memory, fill sweep, scan pipeline, output register
   cbfns_dpath #(
      .MAX_BITS  (MAX_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_dpath (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if),
      .cmd    (cmd),
      .sts    (sts)
   );

endmodule

// ----- sv/cbfns_ctrl.sv -----
// ----------------------------------------------------------------------------
// cbfns_ctrl
// Sequencer: sweep, decode, scan, read-modify-write and response hand-off.
// ----------------------------------------------------------------------------
module cbfns_ctrl import cbfns_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_SWEEP: begin
            if (sts.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (sts.req_fire) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (sts.op == OP_REFILL) begin
               state_in = ST_REFILL;
            end else if (!sts.in_range) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            state_in = (sts.op == OP_FIND) ? ST_SCAN : ST_READ;
         end
         ST_SCAN: begin
            if (sts.hit || (sts.issue_done && sts.pipe_empty)) state_in = ST_DONE;
         end
         ST_READ:   state_in = ST_MODIFY;
         ST_MODIFY: state_in = ST_DONE;
         ST_REFILL: begin
            if (sts.sweep_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (sts.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_SWEEP;
      endcase
      // a register write restarts the fill sweep
      if (sts.csr_fire) state_in = ST_SWEEP;
   end

   // outputs
   always_comb begin
      cmd            = '0;
      cmd.req_open   = (state_ff == ST_IDLE);
      cmd.sweep_step = (state_ff == ST_SWEEP) || (state_ff == ST_REFILL);
      cmd.divide     = (state_ff == ST_DIV);
      cmd.split      = (state_ff == ST_SPLIT);
      cmd.scan_run   = (state_ff == ST_SCAN);
      cmd.scan_issue = (state_ff == ST_SCAN) && !sts.issue_done && !sts.hit;
      cmd.rd_issue   = (state_ff == ST_READ);
      cmd.modify     = (state_ff == ST_MODIFY);
      cmd.load_rsp   = (state_ff == ST_DONE) && sts.rsp_free;
   end

endmodule

// ----- sv/cbfns_dpath.sv -----
// ----------------------------------------------------------------------------
// cbfns_dpath
// Bitmap word memory, fill sweep, position split, scan pipeline and output reg.
// ----------------------------------------------------------------------------
module cbfns_dpath import cbfns_pkg::*; #(
   parameter int unsigned MAX_BITS  = DEF_MAX_BITS,
   parameter int unsigned WORD_BITS = DEF_WORD_BITS
) (
   input  logic        clock,
   input  logic        reset,
   cbfns_req_if.sink   req_if,
   cbfns_rsp_if.source rsp_if,
   cbfns_csr_if.sink   csr_if,
   input  cmd_type     cmd,
   output sts_type     sts
);

   localparam int unsigned WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int unsigned WC_W  = $clog2(WORD_COUNT + 1);
   localparam int unsigned IC_W  = $clog2(WORD_COUNT + 2);
   localparam int unsigned SPAN  = $clog2(WORD_COUNT * WORD_BITS + 1);
   localparam int unsigned LO_W  = (SPAN > CNT_W + 1) ? SPAN : CNT_W + 1;
   localparam int unsigned BW    = $clog2(WORD_BITS);
   localparam int unsigned NG    = (WORD_BITS + GRP_BITS - 1) / GRP_BITS;
   localparam int unsigned GW    = (NG > 1) ? $clog2(NG) : 1;
   localparam int unsigned PADW  = NG * GRP_BITS;
   localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;
   localparam int unsigned CAP   = (MAX_BITS < CNT_MAX) ? MAX_BITS : CNT_MAX;
   localparam int unsigned N_RST = (RESET_COUNT < CAP) ? RESET_COUNT : CAP;
   // word index by reciprocal multiply, exact for all POS_W-bit positions
   localparam int unsigned RSH   = POS_W + $clog2(WORD_BITS);
   localparam int unsigned RM    = ((1 << RSH) + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned PRW   = 2 * POS_W + 1;

   localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

   // word memory
   logic [WORD_BITS-1:0] mem [WORD_COUNT];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 mem_we;
   logic [AW-1:0]        mem_wa;
   logic [AW-1:0]        mem_ra;
   logic [WORD_BITS-1:0] mem_wd;

   // control registers (reset)
   logic [CNT_W-1:0] n_ff,          n_in;
   logic [AW-1:0]    sweep_addr_ff, sweep_addr_in;
   logic [LO_W-1:0]  sweep_lo_ff,   sweep_lo_in;
   logic [WC_W-1:0]  words_ff,      words_in;
   logic             t1_v_ff,       t1_v_in;
   logic             t2_v_ff,       t2_v_in;
   logic             rsp_valid_ff,  rsp_valid_in;

   // payload registers
   op_type                  op_ff,        op_in;
   logic [POS_W-1:0]        pos_ff,       pos_in;
   logic                    in_range_ff,  in_range_in;
   logic [AW-1:0]           sw_ff,        sw_in;
   logic [BW-1:0]           sb_ff,        sb_in;
   logic [AW-1:0]           scan_w_ff,    scan_w_in;
   logic [LO_W-1:0]         scan_lo_ff,   scan_lo_in;
   logic [IC_W-1:0]         issue_cnt_ff, issue_cnt_in;
   logic                    t1_first_ff,  t1_first_in;
   logic                    t1_last_ff,   t1_last_in;
   logic [LO_W-1:0]         t1_lo_ff,     t1_lo_in;
   logic [NG-1:0]           t2_nz_ff,     t2_nz_in;
   logic [NG-1:0][GLW-1:0]  t2_low_ff,    t2_low_in;
   logic [LO_W-1:0]         t2_lo_ff,     t2_lo_in;
   logic                    res_found_ff, res_found_in;
   logic [POS_W-1:0]        res_idx_ff,   res_idx_in;
   logic                    res_bit_ff,   res_bit_in;
   logic                    out_found_ff, out_found_in;
   logic [POS_W-1:0]        out_idx_ff,   out_idx_in;
   logic                    out_bit_ff,   out_bit_in;

   // combinational helpers
   logic                 req_fire;
   logic                 csr_fire;
   logic [LO_W-1:0]      n_ext;
   logic [LO_W-1:0]      fill_diff;
   logic [WORD_BITS-1:0] fill_word;
   logic [PRW-1:0]       recip_prod;
   logic [LO_W-1:0]      lo_start;
   logic                 scan_wrap;
   logic [WORD_BITS-1:0] masked;
   logic [PADW-1:0]      padded;
   logic [GW-1:0]        gsel;

   assign req_fire = req_if.valid && req_if.ready;
   assign csr_fire = csr_if.valid && csr_if.ready;

   assign req_if.ready = cmd.req_open && !csr_if.valid;
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.found      = out_found_ff;
   assign rsp_if.live_index = out_idx_ff;
   assign rsp_if.bit_value  = out_bit_ff;

   // fill value of the word under the sweep: bit b live when lo + b < n
   always_comb begin
      n_ext     = LO_W'(n_ff);
      fill_diff = n_ext - sweep_lo_ff;
      if (sweep_lo_ff >= n_ext) begin
         fill_word = '0;
      end else if (fill_diff >= LO_W'(WORD_BITS)) begin
         fill_word = ONES;
      end else begin
         fill_word = ~(ONES << fill_diff[BW-1:0]);
      end
   end

   assign recip_prod = PRW'(pos_ff) * PRW'(RM);
   assign lo_start   = LO_W'(sw_ff) * LO_W'(WORD_BITS);
   assign scan_wrap  = (IC_W'(scan_w_ff) + IC_W'(1)) == IC_W'(words_ff);

   // first stage of the scan: window mask, per-group flags and low index
   always_comb begin
      masked = rd_data_ff;
      if (t1_first_ff) masked = masked & (ONES << sb_ff);
      if (t1_last_ff)  masked = masked & ~(ONES << sb_ff);
      padded = PADW'(masked);
      for (int g = 0; g < NG; g++) begin
         t2_nz_in[g]  = |padded[g*GRP_BITS +: GRP_BITS];
         t2_low_in[g] = '0;
         for (int b = GRP_BITS - 1; b >= 0; b--) begin
            if (padded[g*GRP_BITS + b]) t2_low_in[g] = GLW'(b);
         end
      end
   end

   // second stage: lowest non-empty group
   always_comb begin
      gsel = '0;
      for (int g = NG - 1; g >= 0; g--) begin
         if (t2_nz_ff[g]) gsel = GW'(g);
      end
   end

   // next-state logic
   always_comb begin
      n_in          = n_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_lo_in   = sweep_lo_ff;
      words_in      = words_ff;
      op_in         = op_ff;
      pos_in        = pos_ff;
      in_range_in   = in_range_ff;
      sw_in         = sw_ff;
      sb_in         = sb_ff;
      scan_w_in     = scan_w_ff;
      scan_lo_in    = scan_lo_ff;
      issue_cnt_in  = issue_cnt_ff;
      t1_v_in       = 1'b0;
      t1_first_in   = issue_cnt_ff == '0;
      t1_last_in    = issue_cnt_ff == IC_W'(words_ff);
      t1_lo_in      = scan_lo_ff;
      t2_v_in       = t1_v_ff && cmd.scan_run;
      t2_lo_in      = t1_lo_ff;
      res_found_in  = res_found_ff;
      res_idx_in    = res_idx_ff;
      res_bit_in    = res_bit_ff;
      out_found_in  = out_found_ff;
      out_idx_in    = out_idx_ff;
      out_bit_in    = out_bit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      mem_we        = 1'b0;
      mem_wa        = sweep_addr_ff;
      mem_wd        = fill_word;
      mem_ra        = cmd.scan_issue ? scan_w_ff : sw_ff;

      // fill sweep, one word a cycle
      if (cmd.sweep_step) begin
         mem_we = 1'b1;
         if (sweep_addr_ff == '0) begin
            words_in = WC_W'(sweep_lo_ff < n_ext);
         end else if (sweep_lo_ff < n_ext) begin
            words_in = WC_W'(sweep_addr_ff) + WC_W'(1);
         end
         if (sweep_addr_ff == AW'(WORD_COUNT - 1)) begin
            sweep_addr_in = '0;
            sweep_lo_in   = '0;
         end else begin
            sweep_addr_in = sweep_addr_ff + AW'(1);
            sweep_lo_in   = sweep_lo_ff + LO_W'(WORD_BITS);
         end
      end

      if (csr_fire) begin
         n_in          = (csr_if.bit_count > CNT_W'(CAP)) ? CNT_W'(CAP) : csr_if.bit_count;
         sweep_addr_in = '0;
         sweep_lo_in   = '0;
      end

      if (req_fire) begin
         op_in        = op_type'(req_if.opcode);
         pos_in       = req_if.position;
         in_range_in  = CNT_W'(req_if.position) < n_ff;
         res_found_in = 1'b0;
         res_idx_in   = '0;
         res_bit_in   = 1'b0;
      end

      if (cmd.divide) sw_in = AW'(recip_prod >> RSH);

      if (cmd.split) begin
         sb_in        = BW'(LO_W'(pos_ff) - lo_start);
         scan_w_in    = sw_ff;
         scan_lo_in   = lo_start;
         issue_cnt_in = '0;
      end

      if (cmd.scan_issue) begin
         t1_v_in      = 1'b1;
         issue_cnt_in = issue_cnt_ff + IC_W'(1);
         if (scan_wrap) begin
            scan_w_in  = '0;
            scan_lo_in = '0;
         end else begin
            scan_w_in  = scan_w_ff + AW'(1);
            scan_lo_in = scan_lo_ff + LO_W'(WORD_BITS);
         end
      end

      // first hit wins; later words still in flight are ignored
      if (cmd.scan_run && t2_v_ff && !res_found_ff && (|t2_nz_ff)) begin
         res_found_in = 1'b1;
         res_idx_in   = POS_W'(t2_lo_ff + LO_W'({gsel, t2_low_ff[gsel]}));
      end

      if (cmd.modify) begin
         res_bit_in = (op_ff == OP_TEST) ? rd_data_ff[sb_ff] : 1'b0;
         if (op_ff == OP_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = sw_ff;
            mem_wd = rd_data_ff & ~(WORD_BITS'(1) << sb_ff);
         end
      end

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         out_found_in = res_found_ff;
         out_idx_in   = res_idx_ff;
         out_bit_in   = res_bit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff          <= CNT_W'(N_RST);
         sweep_addr_ff <= '0;
         sweep_lo_ff   <= '0;
         words_ff      <= '0;
         t1_v_ff       <= 1'b0;
         t2_v_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         n_ff          <= n_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_lo_ff   <= sweep_lo_in;
         words_ff      <= words_in;
         t1_v_ff       <= t1_v_in;
         t2_v_ff       <= t2_v_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      pos_ff       <= pos_in;
      in_range_ff  <= in_range_in;
      sw_ff        <= sw_in;
      sb_ff        <= sb_in;
      scan_w_ff    <= scan_w_in;
      scan_lo_ff   <= scan_lo_in;
      issue_cnt_ff <= issue_cnt_in;
      t1_first_ff  <= t1_first_in;
      t1_last_ff   <= t1_last_in;
      t1_lo_ff     <= t1_lo_in;
      t2_nz_ff     <= t2_nz_in;
      t2_low_ff    <= t2_low_in;
      t2_lo_ff     <= t2_lo_in;
      res_found_ff <= res_found_in;
      res_idx_ff   <= res_idx_in;
      res_bit_ff   <= res_bit_in;
      out_found_ff <= out_found_in;
      out_idx_ff   <= out_idx_in;
      out_bit_ff   <= out_bit_in;
   end

   always_comb begin
      sts            = '0;
      sts.req_fire   = req_fire;
      sts.csr_fire   = csr_fire;
      sts.op         = op_ff;
      sts.in_range   = in_range_ff;
      sts.sweep_last = sweep_addr_ff == AW'(WORD_COUNT - 1);
      sts.issue_done = issue_cnt_ff > IC_W'(words_ff);
      sts.pipe_empty = !t1_v_ff && !t2_v_ff;
      sts.hit        = res_found_ff;
      sts.rsp_free   = !rsp_valid_ff || rsp_if.ready;
   end

endmodule

// ----- sim/circular_bitmap_find_next_set_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_bitmap_find_next_set_unit_tb
// Drives find, clear, test and refill requests through the live-position
// bitmap under several bit_count settings. A behavioural bitmap predicts the
// responses, directed rows may carry hand-worked ones, and the responses are checked field by field, in order.
// ----------------------------------------------------------------------------
module circular_bitmap_find_next_set_unit_tb;
   import cbfns_pkg::*;

   localparam int unsigned MAP_BITS     = DEF_MAX_BITS;
   localparam int unsigned PHASES       = 10;
   localparam int unsigned RANDOM_ITEMS = 1550;
   localparam int unsigned PAUSE_AT     = 700;   // sender drains the block here
   localparam int unsigned HOLD_AT      = 300;   // receiver stalls after this many
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned TAIL_CYCLES  = 80;
   localparam int unsigned SCRIPT_LEN   = 28;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] live_index;
      logic             bit_value;
   } answer_type;

   localparam answer_type QUIET = '0;

   // Directed row: either a bit_count write or a request. Rows flagged typed
   // carry a hand-worked response; the rest take the predictor's.
   typedef struct packed {
      logic             is_write;
      logic [CNT_W-1:0] count;
      op_type           op;
      logic [POS_W-1:0] pos;
      logic             typed;
      answer_type       want;
   } script_row_type;

   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      // full map after reset, word edges at both ends
      '{1'b0, 13'd0, OP_FIND,   12'd0,    1'b1, '{1'b1, 12'd0,    1'b0}},
      '{1'b0, 13'd0, OP_FIND,   12'd4095, 1'b1, '{1'b1, 12'd4095, 1'b0}},
      '{1'b0, 13'd0, OP_TEST,   12'd4095, 1'b1, '{1'b0, 12'd0,    1'b1}},
      '{1'b0, 13'd0, OP_CLEAR,  12'd4095, 1'b1, QUIET},
      '{1'b0, 13'd0, OP_TEST,   12'd4095, 1'b1, QUIET},
      // last position dead: search wraps round to the start
      '{1'b0, 13'd0, OP_FIND,   12'd4095, 1'b1, '{1'b1, 12'd0,    1'b0}},
      '{1'b0, 13'd0, OP_CLEAR,  12'd0,    1'b1, QUIET},
      '{1'b0, 13'd0, OP_FIND,   12'd4095, 1'b1, '{1'b1, 12'd1,    1'b0}},
      // dead pair across the first word boundary
      '{1'b0, 13'd0, OP_CLEAR,  12'd63,   1'b1, QUIET},
      '{1'b0, 13'd0, OP_CLEAR,  12'd64,   1'b1, QUIET},
      '{1'b0, 13'd0, OP_FIND,   12'd62,   1'b0, QUIET},
      '{1'b0, 13'd0, OP_FIND,   12'd63,   1'b1, '{1'b1, 12'd65,   1'b0}},
      '{1'b0, 13'd0, OP_TEST,   12'd2730, 1'b0, QUIET},
      '{1'b0, 13'd0, OP_TEST,   12'd1365, 1'b0, QUIET},
      '{1'b0, 13'd0, OP_REFILL, 12'd0,    1'b1, QUIET},
      '{1'b0, 13'd0, OP_FIND,   12'd4095, 1'b1, '{1'b1, 12'd4095, 1'b0}},
      // count above the maximum clamps to the full map
      '{1'b1, 13'd8191, OP_FIND, 12'd0,   1'b0, QUIET},
      '{1'b0, 13'd0, OP_TEST,   12'd4095, 1'b1, '{1'b0, 12'd0,    1'b1}},
      // ten positions: start, clear and test beyond the count
      '{1'b1, 13'd10, OP_FIND,  12'd0,    1'b0, QUIET},
      '{1'b0, 13'd0, OP_FIND,   12'd10,   1'b1, QUIET},
      '{1'b0, 13'd0, OP_CLEAR,  12'd12,   1'b1, QUIET},
      '{1'b0, 13'd0, OP_TEST,   12'd12,   1'b1, QUIET},
      '{1'b0, 13'd0, OP_FIND,   12'd9,    1'b1, '{1'b1, 12'd9,    1'b0}},
      '{1'b0, 13'd0, OP_CLEAR,  12'd9,    1'b1, QUIET},
      '{1'b0, 13'd0, OP_FIND,   12'd9,    1'b1, '{1'b1, 12'd0,    1'b0}},
      // empty map
      '{1'b1, 13'd0, OP_FIND,   12'd0,    1'b0, QUIET},
      '{1'b0, 13'd0, OP_FIND,   12'd0,    1'b1, QUIET},
      '{1'b0, 13'd0, OP_TEST,   12'd0,    1'b1, QUIET}
   };

   localparam logic [CNT_W-1:0] PHASE_COUNTS [PHASES] = '{
      13'd4096, 13'd1, 13'd64, 13'd65, 13'd8191,
      13'd200, 13'd4095, 13'd127, 13'd0, 13'd777   // last one replaced at random
   };

   logic clock;
   logic reset;

   cbfns_req_if req_if ();
   cbfns_rsp_if rsp_if ();
   cbfns_csr_if csr_if ();

   circular_bitmap_find_next_set_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Behavioural copy of the bitmap, one bit a position
   bit [MAP_BITS-1:0] live_map;
   int unsigned       live_span;      // bit_count clamped to the map size
   int unsigned       scan_cursor;    // drifts along to build runs of dead bits

   answer_type  pending_answers [$];
   int unsigned answers_seen;
   int unsigned fault_count;
   int unsigned random_sent;
   int unsigned send_calm;
   bit          pause_done;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // ----------------------------------------------------------------------
   // Predictor
   // ----------------------------------------------------------------------
   function automatic void refill_map();
      int unsigned i;
      live_map = '0;
      for (i = 0; i < live_span; i++) live_map[i] = 1'b1;
   endfunction

   function automatic void load_count(logic [CNT_W-1:0] value);
      live_span = (value > MAP_BITS) ? MAP_BITS : int'(value);
      refill_map();
   endfunction

   // Applies one request to the bitmap and returns the response it should give
   function automatic answer_type step_bitmap(op_type op, logic [POS_W-1:0] pos);
      answer_type  ans;
      int unsigned k;
      int unsigned p;
      ans = QUIET;
      case (op)
         OP_FIND: begin
            // circular scan over used positions; bits past the count are never set
            if (pos < live_span) begin
               for (k = 0; k < live_span; k++) begin
                  p = pos + k;
                  if (p >= live_span) p -= live_span;
                  if (live_map[p]) begin
                     ans.found      = 1'b1;
                     ans.live_index = POS_W'(p);
                     break;
                  end
               end
            end
         end
         OP_CLEAR: begin
            if (pos < live_span) live_map[pos] = 1'b0;
         end
         OP_TEST: begin
            if (pos < live_span) ans.bit_value = live_map[pos];
         end
         OP_REFILL: begin
            refill_map();
         end
      endcase
      return ans;
   endfunction

   // ----------------------------------------------------------------------
   // Stimulus helpers
   // ----------------------------------------------------------------------
   // Mostly back to back or short, now and then a long gap
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   task automatic sender_idle();
      int unsigned g;
      if (send_calm > 0) begin
         send_calm--;
         g = 0;
      end else begin
         g = pick_gap();
         if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 100);
      end
      repeat (g) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
   endtask

   // Offers one request; valid is left high so the next can follow at once
   task automatic offer(op_type op, logic [POS_W-1:0] pos, bit typed, answer_type want);
      answer_type ans;
      @(negedge clock);
      req_if.valid    <= 1'b1;
      req_if.opcode   <= op;
      req_if.position <= pos;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      ans = step_bitmap(op, pos);
      if (typed) ans = want;
      pending_answers = {pending_answers, ans};
   endtask

   task automatic wait_for_answers();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   // Register writes only go in with the block drained
   task automatic write_bit_count(logic [CNT_W-1:0] value);
      wait_for_answers();
      @(negedge clock);
      csr_if.valid     <= 1'b1;
      csr_if.bit_count <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      load_count(value);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Mostly in range, half of those near a drifting cursor; a tenth anywhere
   function automatic logic [POS_W-1:0] pick_position();
      if (live_span == 0 || $urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, 4095));
      if ($urandom_range(0, 1) == 1) begin
         scan_cursor = (scan_cursor + $urandom_range(0, 5)) % live_span;
         return POS_W'(scan_cursor);
      end
      return POS_W'($urandom_range(0, live_span - 1));
   endfunction

   task automatic run_phase(int unsigned items);
      int unsigned k;
      int unsigned j;
      int unsigned run;
      int unsigned start;
      int unsigned choice;
      op_type      op;
      k = 0;
      while (k < items) begin
         if (!pause_done && random_sent >= PAUSE_AT) begin
            pause_done = 1'b1;
            wait_for_answers();
         end
         choice = $urandom_range(0, 99);
         if (choice < 8 && live_span > 1) begin
            // kill a run of positions, then search from its head so the scan
            // has to step over it (and over word edges for longer runs)
            start = $urandom_range(0, live_span - 1);
            run   = $urandom_range(2, 48);
            for (j = 0; j < run; j++) begin
               sender_idle();
               offer(OP_CLEAR, POS_W'((start + j) % live_span), 1'b0, QUIET);
            end
            sender_idle();
            offer(OP_FIND, POS_W'(start), 1'b0, QUIET);
            k           += run + 1;
            random_sent += run + 1;
         end else begin
            if (choice < 40)      op = OP_FIND;
            else if (choice < 70) op = OP_CLEAR;
            else if (choice < 97) op = OP_TEST;
            else                  op = OP_REFILL;
            sender_idle();
            offer(op, pick_position(), 1'b0, QUIET);
            k++;
            random_sent++;
         end
      end
   endtask

   // ----------------------------------------------------------------------
   // Main sequence
   // ----------------------------------------------------------------------
   initial begin : stimulus
      int unsigned      r;
      int unsigned      p;
      logic [CNT_W-1:0] cnt;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.opcode    = OP_FIND;
      req_if.position  = '0;
      csr_if.valid     = 1'b0;
      csr_if.bit_count = '0;
      answers_seen     = 0;
      fault_count      = 0;
      random_sent      = 0;
      send_calm        = 0;
      scan_cursor      = 0;
      pause_done       = 1'b0;
      load_count(CNT_W'(RESET_COUNT));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows; the block's fill sweep holds off the first request
      for (r = 0; r < SCRIPT_LEN; r++) begin
         if (SCRIPT[r].is_write) begin
            write_bit_count(SCRIPT[r].count);
         end else begin
            sender_idle();
            offer(SCRIPT[r].op, SCRIPT[r].pos, SCRIPT[r].typed, SCRIPT[r].want);
         end
      end

      // random phases, one bit_count setting each
      for (p = 0; p < PHASES; p++) begin
         cnt = (p == PHASES - 1) ? CNT_W'($urandom_range(1, 8191)) : PHASE_COUNTS[p];
         write_bit_count(cnt);
         run_phase(RANDOM_ITEMS / PHASES);
      end

      // drain, then leave room for anything stray
      wait_for_answers();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // ----------------------------------------------------------------------
   // Response side: random back-pressure, calm spells, one long hold
   // ----------------------------------------------------------------------
   initial begin : rsp_drain
      int unsigned g;
      int unsigned calm;
      bit          long_hold_done;
      calm           = 0;
      long_hold_done = 1'b0;
      rsp_if.ready   = 1'b0;
      forever begin
         @(negedge clock);
         if (!long_hold_done && answers_seen >= HOLD_AT) begin
            // requests keep coming: the output register and the one in
            // flight fill up and the request side must stall
            long_hold_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (calm > 0) begin
            calm--;
            rsp_if.ready <= 1'b1;
         end else begin
            g = pick_gap();
            if ($urandom_range(0, 49) == 0) calm = $urandom_range(20, 120);
            if (g == 0) begin
               rsp_if.ready <= 1'b1;
            end else begin
               rsp_if.ready <= 1'b0;
               repeat (g - 1) @(negedge clock);
            end
         end
      end
   end

   // ----------------------------------------------------------------------
   // Response check, oldest expectation first
   // ----------------------------------------------------------------------
   always @(posedge clock) begin : answer_check
      answer_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         answers_seen++;
         if (pending_answers.size() == 0) begin
            fault_count++;
            $display("%0t: response with none pending: found=%0b index=%0d bit=%0b",
                     $time, rsp_if.found, rsp_if.live_index, rsp_if.bit_value);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_if.found !== want.found) begin
               fault_count++;
               $display("%0t: found expected %0b got %0b", $time, want.found, rsp_if.found);
            end
            if (rsp_if.live_index !== want.live_index) begin
               fault_count++;
               $display("%0t: live_index expected %0d got %0d",
                        $time, want.live_index, rsp_if.live_index);
            end
            if (rsp_if.bit_value !== want.bit_value) begin
               fault_count++;
               $display("%0t: bit_value expected %0b got %0b",
                        $time, want.bit_value, rsp_if.bit_value);
            end
         end
      end
   end

   // Watchdog, several times the slowest legal run
   initial begin : watchdog
      #20000000;
      $display("simulation failed");
      $finish;
   end

endmodule
